### rtl/ptq_pkg.sv
// Shared types, codes and defaults for the three-level priority queue.
package ptq_pkg;

    // Default sizing
    localparam int CAPACITY_DEF = 64;
    localparam int TAG_BITS_DEF = 16;

    // Operation codes
    localparam logic [1:0] FN_PUT   = 2'd0;
    localparam logic [1:0] FN_GET   = 2'd1;
    localparam logic [1:0] FN_ACCEL = 2'd2;
    localparam logic [1:0] FN_NOP   = 2'd3;

    // Level codes
    localparam logic [1:0] LVL_LOW    = 2'd0;
    localparam logic [1:0] LVL_NORMAL = 2'd1;
    localparam logic [1:0] LVL_HIGH   = 2'd2;
    localparam logic [1:0] LVL_BAD    = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BAD_PRIO = 2'd3;

    // Request word
    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  priority_level;
        logic [15:0] payload_in;
    } req_word_t;

    // Response word
    typedef struct packed {
        logic [15:0] payload_out;
        logic [1:0]  status;
        logic [6:0]  total_count;
    } rsp_word_t;

    // Memory access strobes from control to store
    typedef struct packed {
        logic rd;
        logic tag_wr;
        logic link_wr;
    } mem_en_t;

endpackage

### rtl/ptq_store.sv
// Tag and link memories with registered read data.
module ptq_store
    import ptq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic                        clk,
    input  mem_en_t                     mem_en,
    input  logic [$clog2(CAPACITY)-1:0] tag_rd_addr,
    input  logic [$clog2(CAPACITY)-1:0] link_rd_addr,
    input  logic [$clog2(CAPACITY)-1:0] tag_wr_addr,
    input  logic [$clog2(CAPACITY)-1:0] link_wr_addr,
    input  logic [TAG_BITS-1:0]         tag_wr_data,
    input  logic [$clog2(CAPACITY)-1:0] link_wr_data,
    output logic [TAG_BITS-1:0]         tag_rd_data,
    output logic [$clog2(CAPACITY)-1:0] link_rd_data
);

    localparam int PTR = $clog2(CAPACITY);

    logic [TAG_BITS-1:0] tag_mem  [CAPACITY];
    logic [PTR-1:0]      link_mem [CAPACITY];
    logic [TAG_BITS-1:0] tag_q_reg;
    logic [PTR-1:0]      link_q_reg;

    // Write tag store
    always_ff @(posedge clk)
    begin
        if (mem_en.tag_wr)
        begin
            tag_mem[tag_wr_addr] <= tag_wr_data;
        end
    end

    // Write link store
    always_ff @(posedge clk)
    begin
        if (mem_en.link_wr)
        begin
            link_mem[link_wr_addr] <= link_wr_data;
        end
    end

    // Read both stores; hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (mem_en.rd)
        begin
            tag_q_reg  <= tag_mem[tag_rd_addr];
            link_q_reg <= link_mem[link_rd_addr];
        end
    end

    assign tag_rd_data  = tag_q_reg;
    assign link_rd_data = link_q_reg;

endmodule

### rtl/ptq_ctrl.sv
// Queue control: list pointers, counts, free list and operation sequencer.
module ptq_ctrl
    import ptq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  req_word_t                   req_word,
    output logic                        req_stall,
    input  logic                        out_free,
    output mem_en_t                     mem_en,
    output logic [$clog2(CAPACITY)-1:0] tag_rd_addr,
    output logic [$clog2(CAPACITY)-1:0] link_rd_addr,
    output logic [$clog2(CAPACITY)-1:0] tag_wr_addr,
    output logic [$clog2(CAPACITY)-1:0] link_wr_addr,
    output logic [TAG_BITS-1:0]         tag_wr_data,
    output logic [$clog2(CAPACITY)-1:0] link_wr_data,
    input  logic [TAG_BITS-1:0]         tag_rd_data,
    input  logic [$clog2(CAPACITY)-1:0] link_rd_data,
    output logic                        res_valid,
    output rsp_word_t                   res_word
);

    localparam int PTR = $clog2(CAPACITY);
    localparam int CNT = $clog2(CAPACITY + 1);
    localparam logic [CNT-1:0] CAP_CNT = CNT'(CAPACITY);

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t              state_reg, state_next;
    logic [1:0]          func_reg, func_next;
    logic [1:0]          prio_reg, prio_next;
    logic [1:0]          lv_reg, lv_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [PTR-1:0]      head_reg [3];
    logic [PTR-1:0]      head_next [3];
    logic [PTR-1:0]      tail_reg [3];
    logic [PTR-1:0]      tail_next [3];
    logic [CNT-1:0]      cnt_reg [3];
    logic [CNT-1:0]      cnt_next [3];
    logic [PTR-1:0]      free_head_reg, free_head_next;
    logic [CNT-1:0]      free_cnt_reg, free_cnt_next;
    logic [CNT-1:0]      fresh_reg, fresh_next;

    logic           accept;
    logic           commit;
    logic [1:0]     sel_lv;
    logic [PTR-1:0] put_slot;
    logic           store_full;
    logic [CNT-1:0] held_next;
    logic [CNT-1:0] held_now;

    assign accept    = req_valid && (state_reg == S_IDLE);
    assign req_stall = (state_reg != S_IDLE);
    assign commit    = (state_reg == S_EXEC) && out_free;

    // Pick the highest non-empty level
    always_comb
    begin
        if (cnt_reg[LVL_HIGH] != '0)
        begin
            sel_lv = LVL_HIGH;
        end
        else if (cnt_reg[LVL_NORMAL] != '0)
        begin
            sel_lv = LVL_NORMAL;
        end
        else
        begin
            sel_lv = LVL_LOW;
        end
    end

    // Issue reads at accept: head of the chosen level, or the free list head for put
    assign tag_rd_addr  = head_reg[sel_lv];
    assign link_rd_addr = (req_word.func == FN_PUT) ? free_head_reg : head_reg[sel_lv];

    assign store_full = (free_cnt_reg == '0) && (fresh_reg == CAP_CNT);
    assign put_slot   = (free_cnt_reg != '0) ? free_head_reg : fresh_reg[PTR-1:0];
    assign tag_wr_data = tag_reg;

    // Latch an accepted request, then execute the held operation once the output is free
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        prio_next      = prio_reg;
        lv_next        = lv_reg;
        tag_next       = tag_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        free_head_next = free_head_reg;
        free_cnt_next  = free_cnt_reg;
        fresh_next     = fresh_reg;
        mem_en         = '0;
        tag_wr_addr    = put_slot;
        link_wr_addr   = tail_reg[LVL_HIGH];
        link_wr_data   = put_slot;
        res_word       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mem_en.rd  = 1'b1;
                    func_next  = req_word.func;
                    prio_next  = req_word.priority_level;
                    lv_next    = sel_lv;
                    tag_next   = TAG_BITS'(req_word.payload_in);
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                    case (func_reg)
                        FN_PUT:
                        begin
                            if (prio_reg == LVL_BAD)
                            begin
                                res_word.status = ST_BAD_PRIO;
                            end
                            else if (store_full)
                            begin
                                res_word.status = ST_FULL;
                            end
                            else
                            begin
                                mem_en.tag_wr = 1'b1;
                                if (cnt_reg[prio_reg] == '0)
                                begin
                                    head_next[prio_reg] = put_slot;
                                end
                                else
                                begin
                                    mem_en.link_wr = 1'b1;
                                    link_wr_addr   = tail_reg[prio_reg];
                                end
                                tail_next[prio_reg] = put_slot;
                                cnt_next[prio_reg]  = cnt_reg[prio_reg] + 1'b1;
                                if (free_cnt_reg != '0)
                                begin
                                    free_head_next = link_rd_data;
                                    free_cnt_next  = free_cnt_reg - 1'b1;
                                end
                                else
                                begin
                                    fresh_next = fresh_reg + 1'b1;
                                end
                            end
                        end
                        FN_GET:
                        begin
                            if (held_now == '0)
                            begin
                                res_word.status = ST_EMPTY;
                            end
                            else
                            begin
                                res_word.payload_out = 16'(tag_rd_data);
                                head_next[lv_reg]    = link_rd_data;
                                cnt_next[lv_reg]     = cnt_reg[lv_reg] - 1'b1;
                                mem_en.link_wr       = 1'b1;
                                link_wr_addr         = head_reg[lv_reg];
                                link_wr_data         = free_head_reg;
                                free_head_next       = head_reg[lv_reg];
                                free_cnt_next        = free_cnt_reg + 1'b1;
                            end
                        end
                        FN_ACCEL:
                        begin
                            if (cnt_reg[LVL_LOW] != '0)
                            begin
                                if (cnt_reg[LVL_HIGH] == '0)
                                begin
                                    head_next[LVL_HIGH] = head_reg[LVL_LOW];
                                end
                                else
                                begin
                                    mem_en.link_wr = 1'b1;
                                    link_wr_addr   = tail_reg[LVL_HIGH];
                                    link_wr_data   = head_reg[LVL_LOW];
                                end
                                tail_next[LVL_HIGH] = tail_reg[LVL_LOW];
                                cnt_next[LVL_HIGH]  = cnt_reg[LVL_HIGH] + cnt_reg[LVL_LOW];
                                cnt_next[LVL_LOW]   = '0;
                            end
                        end
                        default:
                        begin
                            res_word.status = ST_OK;
                        end
                    endcase
                    res_word.total_count = 7'(held_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign held_now  = cnt_reg[0] + cnt_reg[1] + cnt_reg[2];
    assign held_next = cnt_next[0] + cnt_next[1] + cnt_next[2];
    assign res_valid = commit;

    // Hold sequencer state, list pointers and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            func_reg      <= FN_NOP;
            prio_reg      <= LVL_LOW;
            lv_reg        <= LVL_LOW;
            head_reg      <= '{default: '0};
            tail_reg      <= '{default: '0};
            cnt_reg       <= '{default: '0};
            free_head_reg <= '0;
            free_cnt_reg  <= '0;
            fresh_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            prio_reg      <= prio_next;
            lv_reg        <= lv_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            free_head_reg <= free_head_next;
            free_cnt_reg  <= free_cnt_next;
            fresh_reg     <= fresh_next;
        end
    end

    // Hold the put tag
    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    // Every slot ever taken is either held in a level or on the free list
    a_slot_conservation: assert property (@(posedge clk) disable iff (!rst_n)
        (held_now + free_cnt_reg) == fresh_reg)
        else $error("slot accounting broken");

    // Never hand out more fresh slots than the store has
    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= CAP_CNT)
        else $error("fresh slot count beyond capacity");

    // A full report comes only when every slot is in use
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_word.status == ST_FULL) |-> (held_now == CAP_CNT))
        else $error("full reported with free slots");

endmodule

### rtl/three_level_priority_queue_top.sv
// Top level of the three-level priority queue: control, store and response register.
// An accepted word has its memory read registered, then its result is loaded into the
// response register once that register is free. One operation runs at a time, owing to
// the synchronous read of the link and tag memories ahead of the pointer update.
// The response register frees the input side while a result waits to be taken.
// Reset clears all pointers and counts; the queue is empty, memories are not cleared.
module three_level_priority_queue_top
    import ptq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req_word,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp_word
);

    localparam int PTR = $clog2(CAPACITY);

    mem_en_t             mem_en;
    logic [PTR-1:0]      tag_rd_addr;
    logic [PTR-1:0]      link_rd_addr;
    logic [PTR-1:0]      tag_wr_addr;
    logic [PTR-1:0]      link_wr_addr;
    logic [TAG_BITS-1:0] tag_wr_data;
    logic [PTR-1:0]      link_wr_data;
    logic [TAG_BITS-1:0] tag_rd_data;
    logic [PTR-1:0]      link_rd_data;
    logic                res_valid;
    rsp_word_t           res_word;
    logic                out_free;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_word_t           rsp_word_reg;

    ptq_ctrl #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_word     (req_word),
        .req_stall    (req_stall),
        .out_free     (out_free),
        .mem_en       (mem_en),
        .tag_rd_addr  (tag_rd_addr),
        .link_rd_addr (link_rd_addr),
        .tag_wr_addr  (tag_wr_addr),
        .link_wr_addr (link_wr_addr),
        .tag_wr_data  (tag_wr_data),
        .link_wr_data (link_wr_data),
        .tag_rd_data  (tag_rd_data),
        .link_rd_data (link_rd_data),
        .res_valid    (res_valid),
        .res_word     (res_word)
    );

    ptq_store #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) u_store (
        .clk          (clk),
        .mem_en       (mem_en),
        .tag_rd_addr  (tag_rd_addr),
        .link_rd_addr (link_rd_addr),
        .tag_wr_addr  (tag_wr_addr),
        .link_wr_addr (link_wr_addr),
        .tag_wr_data  (tag_wr_data),
        .link_wr_data (link_wr_data),
        .tag_rd_data  (tag_rd_data),
        .link_rd_data (link_rd_data)
    );

    // Response register is free when empty or being drained
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        if (res_valid)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Hold response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Load response word on commit
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_word_reg <= res_word;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // One request at a time: an accepted word stalls the next cycle
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("second word accepted while busy");

    // A commit never overwrites a response still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!rsp_valid_reg || !rsp_stall))
        else $error("response overwritten");

    // A stalled response word holds until it is taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
        else $error("stalled response changed");

endmodule
